@@ hdl/deterministic_miller_rabin_64_macros.svh @@
// Assertion helpers for the primality tester.
`ifndef DETERMINISTIC_MILLER_RABIN_64_MACROS_SVH
`define DETERMINISTIC_MILLER_RABIN_64_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DMR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dmr64_pkg.sv @@
`timescale 1ns / 1ps
package dmr64_pkg;

    localparam int NUM_WIDTH = 64;
    localparam int BASE_COUNT = 12;
    localparam int IDX_WIDTH = $clog2(NUM_WIDTH);
    localparam int K_WIDTH = $clog2(BASE_COUNT + 1);

    typedef logic [NUM_WIDTH-1:0] num_t;
    typedef logic [IDX_WIDTH-1:0] idx_t;
    typedef logic [K_WIDTH-1:0] kidx_t;

    // Fixed witness primes, tried in this order.
    function automatic logic [5:0] witness_base(kidx_t k);
        logic [5:0] b;
        case (k)
            4'd0:    b = 6'd2;
            4'd1:    b = 6'd3;
            4'd2:    b = 6'd5;
            4'd3:    b = 6'd7;
            4'd4:    b = 6'd11;
            4'd5:    b = 6'd13;
            4'd6:    b = 6'd17;
            4'd7:    b = 6'd19;
            4'd8:    b = 6'd23;
            4'd9:    b = 6'd29;
            4'd10:   b = 6'd31;
            4'd11:   b = 6'd37;
            default: b = 6'd2;
        endcase
        return b;
    endfunction

    // (a + b) mod m for a, b below m, without overflowing the word.
    function automatic num_t add_mod(num_t a, num_t b, num_t m);
        num_t gap;
        gap = m - b;
        return (a >= gap) ? (a - gap) : (a + b);
    endfunction

endpackage

@@ hdl/deterministic_miller_rabin_64.sv @@
`timescale 1ns / 1ps
// Deterministic Miller-Rabin primality test of the low NUM_WIDTH bits of candidate,
// using the witnesses 2 through 37. A transfer starts when start is high while busy
// is low; busy then stays high until the answer appears on is_prime with done high
// for exactly one cycle, and the receiver cannot stall it. A candidate below two is
// answered in the next cycle without busy going high. Each modular multiplication is a
// shift-and-add over the multiplier bits on two modular adders, one for the double and
// one for the add, performing a double or an add per cycle. A base costs up to about
// 3*NUM_WIDTH multiplications, while most composites end after the first base.
module deterministic_miller_rabin_64
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] candidate,
    output logic        busy,
    output logic        done,
    output logic        is_prime
);

    `include "deterministic_miller_rabin_64_macros.svh"

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_SPLIT,
        S_BASE,
        S_WRED,
        S_POW,
        S_POWSQ,
        S_POWSH,
        S_CHECK,
        S_SQ,
        S_SQTEST,
        S_MUL_DBL,
        S_MUL_ADD
    } state_t;

    state_t state_reg, ret_reg;
    dmr64_pkg::num_t n_reg, d_reg, e_reg, b_reg, res_reg, acc_reg, mul_a_reg, mul_b_reg;
    dmr64_pkg::idx_t r_reg, i_reg, bit_reg;
    dmr64_pkg::kidx_t k_reg;
    logic dest_b_reg;
    logic done_reg, is_prime_reg;

    dmr64_pkg::num_t nm1;
    dmr64_pkg::num_t one;
    dmr64_pkg::num_t acc_dbl, acc_add;

    logic work_accept;
    logic in_mul;
    dmr64_pkg::kidx_t k_end;

    assign nm1 = n_reg - dmr64_pkg::num_t'(1);
    assign one = dmr64_pkg::num_t'(1);
    assign acc_dbl = dmr64_pkg::add_mod(acc_reg, acc_reg, n_reg);
    assign acc_add = dmr64_pkg::add_mod(acc_reg, mul_a_reg, n_reg);

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign is_prime = is_prime_reg;

    assign work_accept = start && !busy && (candidate[dmr64_pkg::NUM_WIDTH-1:1] != '0);
    assign in_mul = (state_reg == S_MUL_DBL) || (state_reg == S_MUL_ADD);
    assign k_end = dmr64_pkg::kidx_t'(dmr64_pkg::BASE_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg <= S_IDLE;
            done_reg <= 1'b0;
            is_prime_reg <= 1'b0;
            k_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        n_reg <= candidate[dmr64_pkg::NUM_WIDTH-1:0];
                        d_reg <= candidate[dmr64_pkg::NUM_WIDTH-1:0]
                                 - dmr64_pkg::num_t'(1);
                        r_reg <= '0;
                        k_reg <= '0;
                        if (candidate[dmr64_pkg::NUM_WIDTH-1:0] < dmr64_pkg::num_t'(2))
                        begin
                            is_prime_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                        else
                            state_reg <= S_SPLIT;
                    end
                end
                S_SPLIT:
                begin
                    if (d_reg[0] == 1'b0)
                    begin
                        d_reg <= d_reg >> 1;
                        r_reg <= r_reg + dmr64_pkg::idx_t'(1);
                    end
                    else
                        state_reg <= S_BASE;
                end
                S_BASE:
                begin
                    if (k_reg == dmr64_pkg::kidx_t'(dmr64_pkg::BASE_COUNT))
                    begin
                        is_prime_reg <= 1'b1;
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (n_reg == dmr64_pkg::num_t'(dmr64_pkg::witness_base(k_reg)))
                    begin
                        is_prime_reg <= 1'b1;
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        b_reg <= dmr64_pkg::num_t'(dmr64_pkg::witness_base(k_reg));
                        state_reg <= S_WRED;
                    end
                end
                S_WRED:
                begin
                    // Bring the base below n by repeated subtraction; it is tiny.
                    if (b_reg >= n_reg)
                        b_reg <= b_reg - n_reg;
                    else
                    begin
                        res_reg <= one;
                        e_reg <= d_reg;
                        state_reg <= S_POW;
                    end
                end
                S_POW:
                begin
                    if (e_reg == '0)
                        state_reg <= S_CHECK;
                    else if (e_reg[0])
                    begin
                        mul_a_reg <= b_reg;
                        mul_b_reg <= res_reg;
                        dest_b_reg <= 1'b0;
                        acc_reg <= '0;
                        bit_reg <= dmr64_pkg::idx_t'(dmr64_pkg::NUM_WIDTH - 1);
                        ret_reg <= S_POWSQ;
                        state_reg <= S_MUL_DBL;
                    end
                    else
                        state_reg <= S_POWSQ;
                end
                S_POWSQ:
                begin
                    mul_a_reg <= b_reg;
                    mul_b_reg <= b_reg;
                    dest_b_reg <= 1'b1;
                    acc_reg <= '0;
                    bit_reg <= dmr64_pkg::idx_t'(dmr64_pkg::NUM_WIDTH - 1);
                    ret_reg <= S_POWSH;
                    state_reg <= S_MUL_DBL;
                end
                S_POWSH:
                begin
                    e_reg <= e_reg >> 1;
                    state_reg <= S_POW;
                end
                S_CHECK:
                begin
                    i_reg <= dmr64_pkg::idx_t'(1);
                    if (res_reg == one || res_reg == nm1)
                    begin
                        k_reg <= k_reg + dmr64_pkg::kidx_t'(1);
                        state_reg <= S_BASE;
                    end
                    else
                        state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    if (i_reg < r_reg)
                    begin
                        mul_a_reg <= res_reg;
                        mul_b_reg <= res_reg;
                        dest_b_reg <= 1'b0;
                        acc_reg <= '0;
                        bit_reg <= dmr64_pkg::idx_t'(dmr64_pkg::NUM_WIDTH - 1);
                        ret_reg <= S_SQTEST;
                        state_reg <= S_MUL_DBL;
                    end
                    else
                    begin
                        is_prime_reg <= 1'b0;
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_SQTEST:
                begin
                    if (res_reg == nm1)
                    begin
                        k_reg <= k_reg + dmr64_pkg::kidx_t'(1);
                        state_reg <= S_BASE;
                    end
                    else
                    begin
                        i_reg <= i_reg + dmr64_pkg::idx_t'(1);
                        state_reg <= S_SQ;
                    end
                end
                S_MUL_DBL:
                begin
                    acc_reg <= acc_dbl;
                    state_reg <= S_MUL_ADD;
                end
                S_MUL_ADD:
                begin
                    if (bit_reg == '0)
                    begin
                        if (dest_b_reg)
                            b_reg <= mul_b_reg[0] ? acc_add : acc_reg;
                        else
                            res_reg <= mul_b_reg[0] ? acc_add : acc_reg;
                        state_reg <= ret_reg;
                    end
                    else
                    begin
                        if (mul_b_reg[bit_reg])
                            acc_reg <= acc_add;
                        bit_reg <= bit_reg - dmr64_pkg::idx_t'(1);
                        state_reg <= S_MUL_DBL;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    `DMR_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
    `DMR_ASSERT_NEXT(a_start_busy, work_accept, busy, "accepted candidate did not start work")
    `DMR_ASSERT_NOW(a_acc_range, in_mul, acc_reg < n_reg, "accumulator not reduced")
    `DMR_ASSERT_NOW(a_k_range, busy, k_reg <= k_end, "base index out of range")

endmodule
